>>> src/lvng_pkg.sv
// ----------------------------------------------------------------------------
// lvng_pkg
// Shared constants, types and functions of the LED value noise generator:
// strip geometry, smoothstep weight table, xorshift16 step and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package lvng_pkg;

    localparam int LED_COUNT      = 660;
    localparam int SEGMENT_LENGTH = 32;
    localparam int POINT_COUNT    = 22;

    localparam logic [15:0] SEED_RESET = 16'h12fe;

    localparam int PIX_W    = 10;
    localparam int VAL_W    = 8;
    localparam int GEN_W    = 16;
    localparam int WGT_W    = 17;
    localparam int SEG_SH   = $clog2(SEGMENT_LENGTH);
    localparam int OFS_SH   = VAL_W - SEG_SH;
    localparam int COL_W    = PIX_W - SEG_SH;
    localparam int PT_AW    = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1;
    localparam int PROD_W   = VAL_W + 1 + WGT_W + 1;

    localparam longint unsigned SS_DIV   = 64'd16581375;
    localparam longint unsigned SS_ROUND = 64'd8290687;

    // read address select
    localparam logic [1:0] ADDR_COL  = 2'd0;
    localparam logic [1:0] ADDR_COL1 = 2'd1;
    localparam logic [1:0] ADDR_IDX  = 2'd2;

    typedef logic [255:0][WGT_W-1:0] ss_table_t;

    typedef struct packed {
        logic [1:0] addr_sel;
        logic       mul_en;
        logic       mul_pix;
        logic       cp0_en;
        logic       cp1_en;
        logic       out_load;
        logic       pix_adv;
        logic       seed_load;
        logic       idx_clr;
        logic       idx_inc;
        logic       fill_old_we;
        logic       fill_new_we;
        logic       adv_we;
    } lvng_cmd_t;

    typedef struct packed {
        logic idx_last;
        logic rows_wrap;
    } lvng_sts_t;

    function automatic ss_table_t build_ss_table();
        ss_table_t        tbl;
        longint unsigned  ov;
        longint unsigned  num;
        for (int i = 0; i < 256; i++) begin
            ov     = longint'(i);
            num    = 64'd65536 * ov * ov * (64'd765 - 64'd2 * ov);
            tbl[i] = WGT_W'((num + SS_ROUND) / SS_DIV);
        end
        return tbl;
    endfunction

    localparam ss_table_t SS_TABLE = build_ss_table();

    function automatic logic [GEN_W-1:0] xorshift16(input logic [GEN_W-1:0] s);
        logic [GEN_W-1:0] t;
        t = s ^ (s << 7);
        t = t ^ (t >> 9);
        t = t ^ (t << 8);
        return t;
    endfunction

endpackage

>>> src/led_value_noise_generator_top.sv
// ----------------------------------------------------------------------------
// led_value_noise_generator_top
// Animated 1-D value noise for an LED strip: one palette index per request.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    pixel_request
//  out      out_valid / out_ready  palette_index, pixel_number, frame_last
//  cfg      cfg_valid / cfg_ready  noise_seed
//
//  A pixel passes from transfer to result through the registered row reads
//  and three passes through the one shared blend multiplier, and a new
//  input is taken only once the last pixel is through.
//  After reset and after every seed transfer a row fill runs
//  with in_ready low; a row advance of the same length follows the last
//  pixel of every 256th frame.
//  A held result stalls the next pixel only at its final step.
// ----------------------------------------------------------------------------
module led_value_noise_generator_top
    import lvng_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             pixel_request,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [VAL_W-1:0] palette_index,
    output logic [PIX_W-1:0] pixel_number,
    output logic             frame_last,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [GEN_W-1:0] noise_seed
);

    lvng_cmd_t cmd;
    lvng_sts_t sts;

    lvng_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_request (pixel_request),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cmd           (cmd),
        .sts           (sts)
    );

    lvng_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .noise_seed    (noise_seed),
        .cmd           (cmd),
        .sts           (sts),
        .palette_index (palette_index),
        .pixel_number  (pixel_number),
        .frame_last    (frame_last)
    );

endmodule

>>> src/lvng_ram.sv
// ----------------------------------------------------------------------------
// lvng_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lvng_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 22
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/lvng_datapath.sv
// ----------------------------------------------------------------------------
// lvng_datapath
// Noise point rows, xorshift16 generator, frame position and a shared
// smoothstep blend unit (one multiplier, registered product).
// ----------------------------------------------------------------------------
module lvng_datapath
    import lvng_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [GEN_W-1:0] noise_seed,
    input  lvng_cmd_t        cmd,
    output lvng_sts_t        sts,
    output logic [VAL_W-1:0] palette_index,
    output logic [PIX_W-1:0] pixel_number,
    output logic             frame_last
);

    logic [GEN_W-1:0]  gen_reg, gen_next;
    logic [VAL_W-1:0]  ofs_reg;
    logic [PIX_W-1:0]  cnt_reg;
    logic [PT_AW-1:0]  idx_reg;

    logic [VAL_W-1:0]  cp0_reg, cp1_reg;
    logic [VAL_W-1:0]  base_reg;
    logic signed [PROD_W-1:0] prod_reg;

    logic [VAL_W-1:0]  pal_reg;
    logic [PIX_W-1:0]  num_reg;
    logic              last_reg;

    logic [COL_W-1:0]  col;
    logic [COL_W:0]    col1;
    logic [PT_AW-1:0]  col_sat, col1_sat, raddr;
    logic [VAL_W-1:0]  pix_ofs;
    logic              pix_last;

    logic [VAL_W-1:0]  old_rd, new_rd;
    logic              old_we, new_we;
    logic [VAL_W-1:0]  old_wd, rnd;

    logic [VAL_W-1:0]  mul_a, mul_b;
    logic [WGT_W-1:0]  mul_w;
    logic signed [VAL_W:0]    diff;
    logic signed [PROD_W-1:0] diff_ext, wgt_ext;
    logic signed [PROD_W-1:0] blend_sum;
    logic [VAL_W-1:0]  blend_out;

    assign col      = cnt_reg[PIX_W-1:SEG_SH];
    assign col1     = {1'b0, col} + 1'b1;
    assign col_sat  = (int'(col) >= POINT_COUNT) ? PT_AW'(POINT_COUNT - 1) : PT_AW'(col);
    assign col1_sat = (int'(col1) >= POINT_COUNT) ? PT_AW'(POINT_COUNT - 1) : PT_AW'(col1);
    assign pix_ofs  = VAL_W'(cnt_reg[SEG_SH-1:0]) << OFS_SH;
    assign pix_last = int'(cnt_reg) >= (LED_COUNT - 1);

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_COL:  raddr = col_sat;
            ADDR_COL1: raddr = col1_sat;
            ADDR_IDX:  raddr = idx_reg;
            default:   raddr = idx_reg;
        endcase
    end

    assign gen_next = xorshift16(gen_reg);
    assign rnd      = gen_next[VAL_W-1:0];
    assign old_we   = cmd.fill_old_we | cmd.adv_we;
    assign new_we   = cmd.fill_new_we | cmd.adv_we;
    assign old_wd   = cmd.adv_we ? new_rd : rnd;

    lvng_ram #(.WIDTH(VAL_W), .DEPTH(POINT_COUNT)) u_older (
        .clk   (clk),
        .we    (old_we),
        .waddr (idx_reg),
        .wdata (old_wd),
        .raddr (raddr),
        .rdata (old_rd)
    );

    lvng_ram #(.WIDTH(VAL_W), .DEPTH(POINT_COUNT)) u_newer (
        .clk   (clk),
        .we    (new_we),
        .waddr (idx_reg),
        .wdata (rnd),
        .raddr (raddr),
        .rdata (new_rd)
    );

    // blend: (a*65536 + (b-a)*w + 32768) >> 16
    assign mul_a = cmd.mul_pix ? cp0_reg : old_rd;
    assign mul_b = cmd.mul_pix ? cp1_reg : new_rd;
    assign mul_w = cmd.mul_pix ? SS_TABLE[pix_ofs] : SS_TABLE[ofs_reg];
    assign diff  = $signed({1'b0, mul_b}) - $signed({1'b0, mul_a});

    assign diff_ext = {{(PROD_W-VAL_W-1){diff[VAL_W]}}, diff};
    assign wgt_ext  = {{(PROD_W-WGT_W){1'b0}}, mul_w};

    assign blend_sum = $signed({{(PROD_W-VAL_W-16){1'b0}}, base_reg, 16'h0000})
                       + prod_reg + $signed(PROD_W'(32768));
    assign blend_out = blend_sum[VAL_W+15:16];

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            base_reg <= mul_a;
            prod_reg <= diff_ext * wgt_ext;
        end
        if (cmd.cp0_en)
        begin
            cp0_reg <= blend_out;
        end
        if (cmd.cp1_en)
        begin
            cp1_reg <= blend_out;
        end
        if (cmd.out_load)
        begin
            pal_reg  <= blend_out;
            num_reg  <= cnt_reg;
            last_reg <= pix_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg <= SEED_RESET;
            ofs_reg <= '0;
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.seed_load)
            begin
                gen_reg <= noise_seed;
                ofs_reg <= '0;
                cnt_reg <= '0;
            end
            else if (old_we | new_we)
            begin
                gen_reg <= gen_next;
            end

            if (cmd.pix_adv)
            begin
                if (pix_last)
                begin
                    cnt_reg <= '0;
                    ofs_reg <= ofs_reg + 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end

            if (cmd.idx_clr || cmd.seed_load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= sts.idx_last ? '0 : idx_reg + 1'b1;
            end
        end
    end

    assign sts.idx_last  = int'(idx_reg) == (POINT_COUNT - 1);
    assign sts.rows_wrap = pix_last && (ofs_reg == '1);

    assign palette_index = pal_reg;
    assign pixel_number  = num_reg;
    assign frame_last    = last_reg;

endmodule

>>> src/lvng_ctrl.sv
// ----------------------------------------------------------------------------
// lvng_ctrl
// Sequencer for row fill, pixel blend and row advance; owns the
// handshakes and the result valid flag.
// ----------------------------------------------------------------------------
module lvng_ctrl
    import lvng_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      pixel_request,
    output logic      out_valid,
    input  logic      out_ready,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    output lvng_cmd_t cmd,
    input  lvng_sts_t sts
);

    localparam logic [3:0] S_FILL_O = 4'd0;
    localparam logic [3:0] S_FILL_N = 4'd1;
    localparam logic [3:0] S_IDLE   = 4'd2;
    localparam logic [3:0] S_RD0    = 4'd3;
    localparam logic [3:0] S_RD1    = 4'd4;
    localparam logic [3:0] S_MC0    = 4'd5;
    localparam logic [3:0] S_MC1    = 4'd6;
    localparam logic [3:0] S_MP     = 4'd7;
    localparam logic [3:0] S_FIN    = 4'd8;
    localparam logic [3:0] S_ADV_RD = 4'd9;
    localparam logic [3:0] S_ADV_WR = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free  = !valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.addr_sel = ADDR_COL;
        state_next = state_reg;
        valid_next = valid_reg && !out_ready;
        case (state_reg)
            S_FILL_O:
            begin
                cmd.fill_old_we = 1'b1;
                state_next      = S_FILL_N;
            end
            S_FILL_N:
            begin
                cmd.fill_new_we = 1'b1;
                cmd.idx_inc     = 1'b1;
                state_next      = sts.idx_last ? S_IDLE : S_FILL_O;
            end
            S_IDLE:
            begin
                if (cfg_valid)
                begin
                    cmd.seed_load = 1'b1;
                    state_next    = S_FILL_O;
                end
                else if (in_valid && pixel_request)
                begin
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.addr_sel = ADDR_COL1;
                cmd.mul_en   = 1'b1;
                state_next   = S_MC0;
            end
            S_MC0:
            begin
                cmd.cp0_en = 1'b1;
                cmd.mul_en = 1'b1;
                state_next = S_MC1;
            end
            S_MC1:
            begin
                cmd.cp1_en = 1'b1;
                state_next = S_MP;
            end
            S_MP:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_pix = 1'b1;
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.pix_adv  = 1'b1;
                    valid_next   = 1'b1;
                    if (sts.rows_wrap)
                    begin
                        cmd.idx_clr = 1'b1;
                        state_next  = S_ADV_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ADV_RD:
            begin
                cmd.addr_sel = ADDR_IDX;
                state_next   = S_ADV_WR;
            end
            S_ADV_WR:
            begin
                cmd.addr_sel = ADDR_IDX;
                cmd.adv_we   = 1'b1;
                cmd.idx_inc  = 1'b1;
                state_next   = sts.idx_last ? S_IDLE : S_ADV_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_FILL_O;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid = valid_reg;

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(valid_reg) |-> $past(state_reg) == S_FIN)
        else $error("result raised outside final step");

    a_cfg_refills: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready) |=> state_reg == S_FILL_O)
        else $error("seed transfer did not start the row fill");

    a_fin_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> (state_reg == S_IDLE || state_reg == S_ADV_RD))
        else $error("bad exit from final step");

    a_fin_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && !out_free) |=> (state_reg == S_FIN && valid_reg))
        else $error("final step left while result pending");

endmodule
